// File: src/conserved_to_complete_gas_state_core_defines.svh
// Assertion macros for the gas state completion core.
`ifndef CONSERVED_TO_COMPLETE_GAS_STATE_CORE_DEFINES_SVH
`define CONSERVED_TO_COMPLETE_GAS_STATE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define CGS_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cgs: same-cycle property violated");

// Implication whose consequent is checked after the delay given by dly.
`define CGS_AFTER(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
    else $error("cgs: delayed property violated");

`endif

// File: src/cgs_pkg.sv
package cgs_pkg;

  localparam int DIM_DEF  = 3;
  localparam int FRAC_DEF = 16;

  // Configuration register indexes
  localparam logic CFG_GAMMA = 1'b0;
  localparam logic CFG_GM1   = 1'b1;

  localparam logic [18:0] GAMMA_RST = 19'd91750;
  localparam logic [17:0] GM1_RST   = 18'd26214;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MASK = 2'd1;
  localparam logic [1:0] ST_PNP  = 2'd2;

  // Fields that ride alongside the arithmetic
  typedef struct packed {
    logic               keep;
    logic signed [31:0] rho;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] mz;
    logic signed [31:0] en;
  } side_t;

endpackage

// File: src/conserved_to_complete_gas_state_core.sv
// Ideal-gas completion core: conserved cell state in, pressure and sound speed out.
// Input: drive the cell fields with start high; the item is taken at an edge where
// busy is low. busy is high only during reset, so one item may enter every cycle.
// Output: done strobes for one cycle with the result fields; the receiver must take
// the item then, there is no backpressure.
// Throughput: one item per cycle. The depth comes from a 64-step bit-per-stage
// divider for |m|^2/(2*rho), a 62-step divider for gamma*p/rho and a 31-step
// digit-per-stage square root, plus eight stages of multiply, sum and compare.
// Configuration: a valid/ready write port (index 0 gamma, index 1 gamma-1), ready
// whenever not in reset; write only while no items are in flight.
// Reset: synchronous, clears all valid bits and reloads gamma 1.4 and gamma-1 0.4;
// items in flight are dropped.
// Masked cells or cells with non-positive density give all-zero fields, status 1.
// Non-positive pressure gives sound speed zero, status 2.
`include "conserved_to_complete_gas_state_core_defines.svh"

module conserved_to_complete_gas_state_core #(
  parameter int DIM       = cgs_pkg::DIM_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cell_valid,
  input  logic signed [31:0] density_in,
  input  logic signed [31:0] momentum_x,
  input  logic signed [31:0] momentum_y,
  input  logic signed [31:0] momentum_z,
  input  logic signed [31:0] energy_in,
  output logic               done,
  output logic [30:0]        density_out,
  output logic signed [31:0] mom_out_x,
  output logic signed [31:0] mom_out_y,
  output logic signed [31:0] mom_out_z,
  output logic signed [31:0] energy_out,
  output logic signed [31:0] pressure_out,
  output logic [30:0]        sound_speed,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [18:0]        cfg_data
);

  localparam int FRAC_BITS = cgs_pkg::FRAC_DEF;
  localparam int MW    = 32 + FRAC_BITS;   // clamped |E - ke| width
  localparam int HW    = MW - 32;          // upper slice of the clamped magnitude
  localparam int PW    = MW + 18;          // (gamma-1) product width
  localparam int DVW   = 94;               // second dividend width
  localparam int N_D1  = 64;
  localparam int N_D2  = 62;
  localparam int N_SQ  = 31;
  localparam int S_SUM = 1;
  localparam int S_D1  = S_SUM + 1;
  localparam int S_E   = S_D1 + N_D1;
  localparam int S_M   = S_E + 1;
  localparam int S_P   = S_M + 1;
  localparam int S_N   = S_P + 1;
  localparam int S_R   = S_N + 1;
  localparam int S_D2  = S_R + 1;
  localparam int S_SQ  = S_D2 + N_D2;
  localparam int N_STG = S_SQ + N_SQ;
  localparam int LAT   = N_STG + 1;

  localparam logic [MW-1:0] CLAMP = {1'b1, {(MW-1){1'b0}}};
  localparam logic [PW-1:0] RND   = PW'((64'd1 << FRAC_BITS) - 64'd1);

  // Configuration registers
  logic [18:0] gamma_ratio;
  logic [17:0] gamma_less_one;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_ratio    <= cgs_pkg::GAMMA_RST;
      gamma_less_one <= cgs_pkg::GM1_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cgs_pkg::CFG_GAMMA: gamma_ratio    <= cfg_data;
        cgs_pkg::CFG_GM1:   gamma_less_one <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // Valid bits and sideband line
  logic            vld  [0:N_STG-1];
  cgs_pkg::side_t  side [0:N_STG-1];
  cgs_pkg::side_t  side_in;
  logic [31:0]     ax, ay, az;

  always_comb begin
    side_in.keep = cell_valid && (density_in > 32'sd0);
    side_in.rho  = density_in;
    side_in.mx   = momentum_x;
    side_in.my   = (DIM >= 2) ? momentum_y : 32'sd0;
    side_in.mz   = (DIM >= 3) ? momentum_z : 32'sd0;
    side_in.en   = energy_in;
    ax = side_in.mx[31] ? (~side_in.mx + 32'd1) : side_in.mx;
    ay = side_in.my[31] ? (~side_in.my + 32'd1) : side_in.my;
    az = side_in.mz[31] ? (~side_in.mz + 32'd1) : side_in.mz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < N_STG; s++) begin
        vld[s] <= 1'b0;
      end
    end else begin
      vld[0] <= start && !busy;
      for (int s = 1; s < N_STG; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    side[0] <= side_in;
    for (int s = 1; s < N_STG; s++) begin
      side[s] <= side[s-1];
    end
  end

  // Squares and their sum
  logic [63:0] sq_x, sq_y, sq_z, sum_s;

  always_ff @(posedge clk) begin
    sq_x  <= ax * ax;
    sq_y  <= ay * ay;
    sq_z  <= az * az;
    sum_s <= sq_x + sq_y + sq_z;
  end

  // Kinetic energy divider, one quotient bit per stage
  logic [31:0] d1_rin [0:N_D1-1];
  logic [63:0] d1_qin [0:N_D1-1];
  logic [31:0] d1_rem [0:N_D1-1];
  logic [63:0] d1_dq  [0:N_D1-1];
  logic [31:0] d1_rem_next [0:N_D1-1];
  logic [63:0] d1_dq_next  [0:N_D1-1];

  always_comb begin
    logic [32:0] t;
    logic [32:0] dv;
    logic        ge;
    d1_rin[0] = 32'd0;
    d1_qin[0] = sum_s;
    for (int k = 1; k < N_D1; k++) begin
      d1_rin[k] = d1_rem[k-1];
      d1_qin[k] = d1_dq[k-1];
    end
    for (int k = 0; k < N_D1; k++) begin
      dv = {1'b0, side[S_SUM+k].rho[30:0], 1'b0};
      t  = {d1_rin[k], d1_qin[k][63]};
      ge = (t >= dv);
      d1_rem_next[k] = ge ? 32'(t - dv) : t[31:0];
      d1_dq_next[k]  = {d1_qin[k][62:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N_D1; k++) begin
      d1_rem[k] <= d1_rem_next[k];
      d1_dq[k]  <= d1_dq_next[k];
    end
  end

  // Internal energy: sign and clamped magnitude
  logic          e_neg;
  logic [MW-1:0] e_mag;
  logic [65:0]   eint;
  logic [64:0]   emag_full;
  logic [MW-1:0] e_mag_next;

  always_comb begin
    eint      = {{34{side[S_E-1].en[31]}}, side[S_E-1].en} - {2'b00, d1_dq[N_D1-1]};
    emag_full = eint[65] ? 65'(~eint + 66'd1) : eint[64:0];
    e_mag_next = (emag_full > 65'(CLAMP)) ? (CLAMP + MW'(1)) : emag_full[MW-1:0];
  end

  always_ff @(posedge clk) begin
    e_neg <= eint[65];
    e_mag <= e_mag_next;
  end

  // (gamma-1) times magnitude, split in two partial products
  logic              m_neg;
  logic [49:0]       m_lo;
  logic [HW+17:0]    m_hi;

  always_ff @(posedge clk) begin
    m_neg <= e_neg;
    m_lo  <= e_mag[31:0] * gamma_less_one;
    m_hi  <= e_mag[MW-1:32] * gamma_less_one;
  end

  // Combine, scale and saturate the pressure
  logic [PW-1:0] prod;
  logic [PW-1:0] prod_rnd;
  logic [49:0]   q_pos;
  logic [31:0]   q_neg;
  logic [31:0]   p_next;
  logic          pos_next;
  logic [31:0]   p_p;
  logic          p_pos;

  always_comb begin
    prod     = {m_hi, 32'd0} + PW'(m_lo);
    prod_rnd = prod + RND;
    q_pos    = prod[PW-1:FRAC_BITS];
    q_neg    = 32'(prod_rnd >> FRAC_BITS);
    if (!m_neg) begin
      p_next   = (q_pos > 50'h7FFFFFFF) ? 32'h7FFFFFFF : q_pos[31:0];
      pos_next = (q_pos != 50'd0);
    end else begin
      p_next   = (prod > PW'(CLAMP)) ? 32'h80000000 : (32'd0 - q_neg);
      pos_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    p_p   <= p_next;
    p_pos <= pos_next;
  end

  // gamma times pressure
  logic [49:0] n_num;
  logic [31:0] n_p;
  logic        n_pos;

  always_ff @(posedge clk) begin
    n_num <= gamma_ratio * p_p[30:0];
    n_p   <= p_p;
    n_pos <= p_pos;
  end

  // Second dividend: top bits decide saturation and seed the remainder, low bits feed the divider
  logic [DVW-1:0] dvd;
  logic [30:0]    r_rem0;
  logic [61:0]    r_low;
  logic [31:0]    rp   [S_R:N_STG-1];
  logic           rpos [S_R:N_STG-1];
  logic           rovf [S_R:N_STG-1];

  assign dvd = DVW'(n_num) << FRAC_BITS;

  always_ff @(posedge clk) begin
    r_rem0  <= dvd[92:62];
    r_low   <= dvd[61:0];
    rp[S_R]   <= n_p;
    rpos[S_R] <= n_pos;
    rovf[S_R] <= (dvd[93:62] >= side[S_N].rho);
    for (int s = S_R + 1; s < N_STG; s++) begin
      rp[s]   <= rp[s-1];
      rpos[s] <= rpos[s-1];
      rovf[s] <= rovf[s-1];
    end
  end

  // gamma*p/rho divider, one quotient bit per stage
  logic [30:0] d2_rin [0:N_D2-1];
  logic [61:0] d2_qin [0:N_D2-1];
  logic [30:0] d2_rem [0:N_D2-1];
  logic [61:0] d2_dq  [0:N_D2-1];
  logic [30:0] d2_rem_next [0:N_D2-1];
  logic [61:0] d2_dq_next  [0:N_D2-1];

  always_comb begin
    logic [31:0] t;
    logic [31:0] dv;
    logic        ge;
    d2_rin[0] = r_rem0;
    d2_qin[0] = r_low;
    for (int k = 1; k < N_D2; k++) begin
      d2_rin[k] = d2_rem[k-1];
      d2_qin[k] = d2_dq[k-1];
    end
    for (int k = 0; k < N_D2; k++) begin
      dv = {1'b0, side[S_R+k].rho[30:0]};
      t  = {d2_rin[k], d2_qin[k][61]};
      ge = (t >= dv);
      d2_rem_next[k] = ge ? 31'(t - dv) : t[30:0];
      d2_dq_next[k]  = {d2_qin[k][60:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N_D2; k++) begin
      d2_rem[k] <= d2_rem_next[k];
      d2_dq[k]  <= d2_dq_next[k];
    end
  end

  // Square root, one result bit per stage
  logic [32:0] sr_rin  [0:N_SQ-1];
  logic [61:0] sr_xin  [0:N_SQ-1];
  logic [30:0] sr_oin  [0:N_SQ-1];
  logic [32:0] sr_rem  [0:N_SQ-1];
  logic [61:0] sr_x    [0:N_SQ-1];
  logic [30:0] sr_root [0:N_SQ-1];
  logic [32:0] sr_rem_next  [0:N_SQ-1];
  logic [61:0] sr_x_next    [0:N_SQ-1];
  logic [30:0] sr_root_next [0:N_SQ-1];

  always_comb begin
    logic [34:0] t;
    logic [34:0] trial;
    logic        ge;
    sr_rin[0] = 33'd0;
    sr_xin[0] = d2_dq[N_D2-1];
    sr_oin[0] = 31'd0;
    for (int j = 1; j < N_SQ; j++) begin
      sr_rin[j] = sr_rem[j-1];
      sr_xin[j] = sr_x[j-1];
      sr_oin[j] = sr_root[j-1];
    end
    for (int j = 0; j < N_SQ; j++) begin
      t     = {sr_rin[j], sr_xin[j][61:60]};
      trial = {2'b00, sr_oin[j], 2'b01};
      ge    = (t >= trial);
      sr_rem_next[j]  = ge ? 33'(t - trial) : t[32:0];
      sr_x_next[j]    = {sr_xin[j][59:0], 2'b00};
      sr_root_next[j] = {sr_oin[j][29:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < N_SQ; j++) begin
      sr_rem[j]  <= sr_rem_next[j];
      sr_x[j]    <= sr_x_next[j];
      sr_root[j] <= sr_root_next[j];
    end
  end

  // Output register: mask, flag and saturate
  cgs_pkg::side_t  fin;
  logic [30:0]     density_out_next;
  logic [31:0]     mom_out_x_next, mom_out_y_next, mom_out_z_next, energy_out_next;
  logic [31:0]     pressure_out_next;
  logic [30:0]     sound_speed_next;
  logic [1:0]      status_next;

  always_comb begin
    fin               = side[N_STG-1];
    density_out_next  = 31'd0;
    mom_out_x_next    = 32'd0;
    mom_out_y_next    = 32'd0;
    mom_out_z_next    = 32'd0;
    energy_out_next   = 32'd0;
    pressure_out_next = 32'd0;
    sound_speed_next  = 31'd0;
    status_next       = cgs_pkg::ST_MASK;
    if (fin.keep) begin
      density_out_next  = fin.rho[30:0];
      mom_out_x_next    = fin.mx;
      mom_out_y_next    = fin.my;
      mom_out_z_next    = fin.mz;
      energy_out_next   = fin.en;
      pressure_out_next = rp[N_STG-1];
      if (rpos[N_STG-1]) begin
        sound_speed_next = rovf[N_STG-1] ? 31'h7FFFFFFF : sr_root[N_SQ-1];
        status_next      = cgs_pkg::ST_OK;
      end else begin
        status_next      = cgs_pkg::ST_PNP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[N_STG-1];
    end
    density_out  <= density_out_next;
    mom_out_x    <= mom_out_x_next;
    mom_out_y    <= mom_out_y_next;
    mom_out_z    <= mom_out_z_next;
    energy_out   <= energy_out_next;
    pressure_out <= pressure_out_next;
    sound_speed  <= sound_speed_next;
    status       <= status_next;
  end

  // Checks
  `CGS_AFTER(a_latency, start && !busy, LAT, done)
  `CGS_IMPLY(a_mask_zero, done && status == cgs_pkg::ST_MASK, density_out == 31'd0 && pressure_out == 32'sd0 && sound_speed == 31'd0)
  `CGS_IMPLY(a_pnp_speed, done && status == cgs_pkg::ST_PNP, sound_speed == 31'd0 && pressure_out <= 32'sd0)
  `CGS_IMPLY(a_ok_press, done && status == cgs_pkg::ST_OK, pressure_out > 32'sd0)

endmodule
